// File: src/ctok_pkg.sv
// Shared types, constants and byte classifiers for the C source tokenizer.
// Used by every module of the block; depends on nothing else.
package ctok_pkg;

  // Line counter width and saturation value
  localparam int unsigned LineBits = 20;
  localparam logic [LineBits-1:0] LineMax = {LineBits{1'b1}};
  localparam logic [LineBits-1:0] LineFirst = LineBits'(1);

  // Depth of the queue between the lexer and the output stage
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrBits = $clog2(QDepth);

  // Source bytes with a special meaning
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChLowE   = 8'h65;
  localparam logic [7:0] ChUpE    = 8'h45;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;

  typedef logic [LineBits-1:0] line_t;

  // Token kind codes as seen on the output
  typedef enum logic [2:0] {
    KindIdent  = 3'd0,
    KindNumber = 3'd1,
    KindString = 3'd2,
    KindChar   = 3'd3,
    KindPunct  = 3'd4,
    KindEnd    = 3'd5
  } kind_e;

  // Lexer mode, one-hot
  typedef enum logic [6:0] {
    ModeBetween  = 7'b0000001,
    ModeIdent    = 7'b0000010,
    ModeNumber   = 7'b0000100,
    ModeString   = 7'b0001000,
    ModeChar     = 7'b0010000,
    ModeLineCom  = 7'b0100000,
    ModeBlockCom = 7'b1000000
  } mode_e;

  // One output transaction
  typedef struct packed {
    logic [7:0] ch;
    kind_e      kind;
    logic       start;
    line_t      line;
  } res_t;

  // One queue entry: the results caused by one source byte (one or two)
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

endpackage

// File: src/ctok_front.sv
// Lexer front end: accepts source bytes, tracks the lexer mode and the
// line counter, and pushes the results of each byte into the queue.
// Depends on ctok_pkg.
module ctok_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       char_code_i,
  input  logic             q_full_i,
  output logic             push_o,
  output ctok_pkg::entry_t push_entry_o
);

  ctok_pkg::mode_e mode_q, mode_d;
  logic            slash_q, slash_d;
  logic            esc_q, esc_d;
  logic            star_q, star_d;
  ctok_pkg::line_t line_q, line_d;

  logic            accept;
  logic            bump;
  logic            at_end;
  logic            r0_v;
  ctok_pkg::entry_t ent;

  // Outcome of handling the byte as if between tokens
  ctok_pkg::mode_e beg_mode;
  logic            beg_slash;
  logic            beg_bump;
  logic            beg_emit;
  logic            beg_clr_esc;
  ctok_pkg::kind_e beg_kind;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Classify the byte for the between-tokens case
  always_comb begin
    beg_mode    = ctok_pkg::ModeBetween;
    beg_slash   = 1'b0;
    beg_bump    = 1'b0;
    beg_emit    = 1'b0;
    beg_clr_esc = 1'b0;
    beg_kind    = ctok_pkg::KindPunct;
    if (ctok_pkg::is_space(char_code_i)) begin
      beg_bump = (char_code_i == ctok_pkg::ChNl);
    end else if (char_code_i == ctok_pkg::ChSlash) begin
      beg_slash = 1'b1;
    end else if (ctok_pkg::is_alpha(char_code_i) || char_code_i == ctok_pkg::ChUnder) begin
      beg_mode = ctok_pkg::ModeIdent;
      beg_emit = 1'b1;
      beg_kind = ctok_pkg::KindIdent;
    end else if (ctok_pkg::is_digit(char_code_i)) begin
      beg_mode = ctok_pkg::ModeNumber;
      beg_emit = 1'b1;
      beg_kind = ctok_pkg::KindNumber;
    end else if (char_code_i == ctok_pkg::ChDquote) begin
      beg_mode    = ctok_pkg::ModeString;
      beg_emit    = 1'b1;
      beg_clr_esc = 1'b1;
      beg_kind    = ctok_pkg::KindString;
    end else if (char_code_i == ctok_pkg::ChSquote) begin
      beg_mode    = ctok_pkg::ModeChar;
      beg_emit    = 1'b1;
      beg_clr_esc = 1'b1;
      beg_kind    = ctok_pkg::KindChar;
    end else begin
      beg_emit = 1'b1;
    end
  end

  // Next state and results of the current byte
  always_comb begin
    mode_d   = mode_q;
    slash_d  = slash_q;
    esc_d    = esc_q;
    star_d   = star_q;
    bump     = 1'b0;
    at_end   = 1'b0;
    r0_v     = 1'b0;
    ent.two      = 1'b0;
    ent.r0.ch    = char_code_i;
    ent.r0.kind  = beg_kind;
    ent.r0.start = 1'b1;
    ent.r0.line  = line_q;
    ent.r1.ch    = char_code_i;
    ent.r1.kind  = beg_kind;
    ent.r1.start = 1'b1;
    ent.r1.line  = line_q;

    if (char_code_i == ctok_pkg::ChNul) begin
      // End of source: flush a held slash, give the end item, reset
      at_end = 1'b1;
      r0_v   = 1'b1;
      mode_d = ctok_pkg::ModeBetween;
      slash_d = 1'b0;
      esc_d  = 1'b0;
      star_d = 1'b0;
      if (slash_q) begin
        ent.r0.ch    = ctok_pkg::ChSlash;
        ent.r0.kind  = ctok_pkg::KindPunct;
        ent.two      = 1'b1;
        ent.r1.ch    = ctok_pkg::ChNul;
        ent.r1.kind  = ctok_pkg::KindEnd;
        ent.r1.start = 1'b0;
      end else begin
        ent.r0.ch    = ctok_pkg::ChNul;
        ent.r0.kind  = ctok_pkg::KindEnd;
        ent.r0.start = 1'b0;
      end
    end else if (slash_q) begin
      // Resolve the held slash
      slash_d = 1'b0;
      if (char_code_i == ctok_pkg::ChSlash) begin
        mode_d = ctok_pkg::ModeLineCom;
      end else if (char_code_i == ctok_pkg::ChStar) begin
        mode_d = ctok_pkg::ModeBlockCom;
        star_d = 1'b0;
      end else begin
        r0_v        = 1'b1;
        ent.r0.ch   = ctok_pkg::ChSlash;
        ent.r0.kind = ctok_pkg::KindPunct;
        ent.two     = beg_emit;
        mode_d      = beg_mode;
        slash_d     = beg_slash;
        bump        = beg_bump;
        if (beg_clr_esc) begin
          esc_d = 1'b0;
        end
      end
    end else begin
      case (mode_q)
        ctok_pkg::ModeIdent: begin
          if (ctok_pkg::is_alpha(char_code_i) || ctok_pkg::is_digit(char_code_i) ||
              char_code_i == ctok_pkg::ChUnder) begin
            r0_v         = 1'b1;
            ent.r0.kind  = ctok_pkg::KindIdent;
            ent.r0.start = 1'b0;
          end else begin
            r0_v    = beg_emit;
            mode_d  = beg_mode;
            slash_d = beg_slash;
            bump    = beg_bump;
            if (beg_clr_esc) begin
              esc_d = 1'b0;
            end
          end
        end
        ctok_pkg::ModeNumber: begin
          if (ctok_pkg::is_digit(char_code_i) ||
              char_code_i inside {ctok_pkg::ChDot, ctok_pkg::ChLowE, ctok_pkg::ChUpE,
                                  ctok_pkg::ChPlus, ctok_pkg::ChMinus}) begin
            r0_v         = 1'b1;
            ent.r0.kind  = ctok_pkg::KindNumber;
            ent.r0.start = 1'b0;
          end else begin
            r0_v    = beg_emit;
            mode_d  = beg_mode;
            slash_d = beg_slash;
            bump    = beg_bump;
            if (beg_clr_esc) begin
              esc_d = 1'b0;
            end
          end
        end
        ctok_pkg::ModeString, ctok_pkg::ModeChar: begin
          r0_v         = 1'b1;
          ent.r0.start = 1'b0;
          ent.r0.kind  = (mode_q == ctok_pkg::ModeString) ? ctok_pkg::KindString
                                                          : ctok_pkg::KindChar;
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (char_code_i == ctok_pkg::ChBslash) begin
            esc_d = 1'b1;
          end else if ((mode_q == ctok_pkg::ModeString && char_code_i == ctok_pkg::ChDquote) ||
                       (mode_q == ctok_pkg::ModeChar && char_code_i == ctok_pkg::ChSquote)) begin
            mode_d = ctok_pkg::ModeBetween;
          end
        end
        ctok_pkg::ModeLineCom: begin
          if (char_code_i == ctok_pkg::ChNl) begin
            mode_d = ctok_pkg::ModeBetween;
            bump   = 1'b1;
          end
        end
        ctok_pkg::ModeBlockCom: begin
          if (star_q && char_code_i == ctok_pkg::ChSlash) begin
            mode_d = ctok_pkg::ModeBetween;
            star_d = 1'b0;
          end else begin
            star_d = (char_code_i == ctok_pkg::ChStar);
            bump   = (char_code_i == ctok_pkg::ChNl);
          end
        end
        default: begin
          r0_v    = beg_emit;
          mode_d  = beg_mode;
          slash_d = beg_slash;
          bump    = beg_bump;
          if (beg_clr_esc) begin
            esc_d = 1'b0;
          end
        end
      endcase
    end
  end

  // Saturating line counter, back to the first line after the end item
  always_comb begin
    line_d = line_q;
    if (at_end) begin
      line_d = ctok_pkg::LineFirst;
    end else if (bump && line_q != ctok_pkg::LineMax) begin
      line_d = line_q + ctok_pkg::LineBits'(1);
    end
  end

  assign push_o       = accept && r0_v;
  assign push_entry_o = ent;

  // Advance lexer state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ctok_pkg::ModeBetween;
      slash_q <= 1'b0;
      esc_q   <= 1'b0;
      star_q  <= 1'b0;
      line_q  <= ctok_pkg::LineFirst;
    end else if (accept) begin
      mode_q  <= mode_d;
      slash_q <= slash_d;
      esc_q   <= esc_d;
      star_q  <= star_d;
      line_q  <= line_d;
    end
  end

`ifndef SYNTHESIS
  a_slash_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slash_q |-> mode_q == ctok_pkg::ModeBetween)
    else $error("slash held outside between-tokens mode");

  a_esc_in_literal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (mode_q == ctok_pkg::ModeString || mode_q == ctok_pkg::ModeChar))
    else $error("escape pending outside a literal");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line counter reached zero");
`endif

endmodule

// File: src/ctok_queue.sv
// Small queue of result entries between the lexer and the output stage.
// Depends on ctok_pkg.
module ctok_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ctok_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ctok_pkg::entry_t head_o
);

  ctok_pkg::entry_t               mem_q [ctok_pkg::QDepth];
  logic [ctok_pkg::QPtrBits-1:0]  wr_ptr_q;
  logic [ctok_pkg::QPtrBits-1:0]  rd_ptr_q;
  logic [ctok_pkg::QPtrBits:0]    count_q, count_d;
  logic                           do_push;
  logic                           do_pop;

  assign full_o  = (count_q == (ctok_pkg::QPtrBits+1)'(ctok_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Track fill level
  always_comb begin
    count_d = count_q;
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + (ctok_pkg::QPtrBits+1)'(1);
      2'b01:   count_d = count_q - (ctok_pkg::QPtrBits+1)'(1);
      default: count_d = count_q;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + ctok_pkg::QPtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + ctok_pkg::QPtrBits'(1);
      end
      count_q <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (ctok_pkg::QPtrBits+1)'(ctok_pkg::QDepth))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0 && count_q != (ctok_pkg::QPtrBits+1)'(ctok_pkg::QDepth)) |->
      wr_ptr_q != rd_ptr_q)
    else $error("queue pointers disagree with count");
`endif

endmodule

// File: src/ctok_back.sv
// Output stage: unpacks queue entries into single result transactions and
// holds them in the output register. Depends on ctok_pkg.
module ctok_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  ctok_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ctok_pkg::res_t   out_res_o
);

  logic           out_valid_q;
  ctok_pkg::res_t out_res_q;
  logic           sec_valid_q;
  ctok_pkg::res_t sec_res_q;
  logic           load;

  // Output register can take a new result when empty or being drained
  assign load  = !out_valid_q || !out_stall_i;
  assign pop_o = load && !sec_valid_q && !empty_i;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (load) begin
      if (sec_valid_q) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= 1'b0;
      end else if (!empty_i) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= head_i.two;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_valid_q) begin
        out_res_q <= sec_res_q;
      end else if (!empty_i) begin
        out_res_q <= head_i.r0;
        sec_res_q <= head_i.r1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`ifndef SYNTHESIS
  a_sec_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_valid_q |-> out_valid_q)
    else $error("second result pending without a first one shown");

  a_no_pop_with_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_valid_q |-> !pop_o)
    else $error("queue popped while second result pending");
`endif

endmodule

// File: src/c_source_tokenizer_core.sv
// C source tokenizer, top level: one source byte is accepted per clock
// unless stalled, byte 0 marking end of source. Each byte yields zero, one
// or two token transactions; each result passes through the queue into
// the output register. The output stage gives one transaction per clock
// unless stalled, so a byte that yields two (a held slash flushed ahead of
// the next token byte, or ahead of the end item) gives them in turn; a
// four-entry queue between the lexer and the output stage absorbs these
// and lets either side stall on its own. Input stall rises only when that
// queue is full. After the end item the line counter restarts at 1.
// Depends on ctok_pkg, ctok_front, ctok_queue and ctok_back.
module c_source_tokenizer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    char_code_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_char_o,
  output logic [2:0]                    token_kind_o,
  output logic                          token_start_o,
  output logic [ctok_pkg::LineBits-1:0] line_number_o
);

  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  ctok_pkg::entry_t push_entry;
  ctok_pkg::entry_t head;
  ctok_pkg::res_t   out_res;

  ctok_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  ctok_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .empty_o      (q_empty),
    .head_o       (head)
  );

  ctok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  // Unpack the output transaction onto its ports
  assign out_char_o    = out_res.ch;
  assign token_kind_o  = out_res.kind;
  assign token_start_o = out_res.start;
  assign line_number_o = out_res.line;

endmodule

// File: test/c_source_tokenizer_core_test.sv
// Self-checking testbench for c_source_tokenizer_core: byte stream in, token transactions out.
// Needs ctok_pkg for the kind codes, the special bytes and the line width.
// Expected tokens are predicted by its own model or typed in; each is checked as it leaves.
module c_source_tokenizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 5_000_000;
  localparam int HoldOffCycles = 120;
  localparam int RandomBytes = 1700;
  localparam int PhaseBytes = 150;
  localparam int DrainCycles = 20;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [7:0]      char_code_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [7:0]      out_char_o;
  logic [2:0]      token_kind_o;
  logic            token_start_o;
  ctok_pkg::line_t line_number_o;

  c_source_tokenizer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .token_kind_o  (token_kind_o),
    .token_start_o (token_start_o),
    .line_number_o (line_number_o)
  );

  // Lexer state as the block should hold it
  ctok_pkg::mode_e lex_mode;
  bit              slash_pend;
  bit              esc_pend;
  bit              star_pend;
  ctok_pkg::line_t cur_line;

  ctok_pkg::res_t step_out[$];        // tokens caused by the byte just accepted
  ctok_pkg::res_t pending_tokens[$];  // tokens still owed by the block, oldest first
  logic [7:0] frag[$];                // bytes of the next random source fragment

  int src_pct;
  int dst_pct;
  bit hold_req;
  int fail_count;
  int bytes_sent;
  int tokens_checked;
  int ends_seen;
  int in_held_cycles;
  int unsigned cycle_count;

  // Directed source: the expected tokens are typed in where they are obvious
  typedef struct {
    logic [7:0]     ch;
    int             n_typed;
    ctok_pkg::res_t t0;
    ctok_pkg::res_t t1;
  } row_t;

  localparam ctok_pkg::res_t NoTok = '0;

  row_t script[29] = '{
    // 'a' after reset
    '{8'h61, 1, '{8'h61, ctok_pkg::KindIdent, 1'b1, ctok_pkg::LineFirst}, NoTok},
    '{ctok_pkg::ChUnder,  0, NoTok, NoTok},
    '{8'h39,              0, NoTok, NoTok},   // '9' inside identifier
    '{ctok_pkg::ChPlus,   0, NoTok, NoTok},   // ends identifier
    '{8'h37,              0, NoTok, NoTok},   // '7' opens number
    '{ctok_pkg::ChMinus,  0, NoTok, NoTok},
    '{ctok_pkg::ChNl,     0, NoTok, NoTok},
    '{ctok_pkg::ChDquote, 0, NoTok, NoTok},
    '{ctok_pkg::ChBslash, 0, NoTok, NoTok},
    '{ctok_pkg::ChDquote, 0, NoTok, NoTok},   // escaped quote
    '{ctok_pkg::ChNl,     0, NoTok, NoTok},   // newline kept in string
    '{ctok_pkg::ChDquote, 0, NoTok, NoTok},
    '{ctok_pkg::ChSquote, 0, NoTok, NoTok},
    '{ctok_pkg::ChBslash, 0, NoTok, NoTok},   // backslash right before end
    '{ctok_pkg::ChNul, 1,
      '{ctok_pkg::ChNul, ctok_pkg::KindEnd, 1'b0, ctok_pkg::line_t'(2)}, NoTok},
    '{ctok_pkg::ChSlash,  0, NoTok, NoTok},
    '{ctok_pkg::ChSlash,  0, NoTok, NoTok},   // line comment
    '{8'h78,              0, NoTok, NoTok},
    '{ctok_pkg::ChNl,     0, NoTok, NoTok},
    '{ctok_pkg::ChSlash,  0, NoTok, NoTok},
    '{ctok_pkg::ChStar,   0, NoTok, NoTok},   // block comment
    '{ctok_pkg::ChSlash,  0, NoTok, NoTok},   // slash right after the opener does not close
    '{ctok_pkg::ChStar,   0, NoTok, NoTok},
    '{ctok_pkg::ChSlash,  0, NoTok, NoTok},   // close
    '{ctok_pkg::ChSlash,  0, NoTok, NoTok},
    '{8'hFF, 2,
      '{ctok_pkg::ChSlash, ctok_pkg::KindPunct, 1'b1, ctok_pkg::line_t'(2)},
      '{8'hFF, ctok_pkg::KindPunct, 1'b1, ctok_pkg::line_t'(2)}},
    '{ctok_pkg::ChSlash,  0, NoTok, NoTok},
    '{ctok_pkg::ChNul, 2,
      '{ctok_pkg::ChSlash, ctok_pkg::KindPunct, 1'b1, ctok_pkg::line_t'(2)},
      '{ctok_pkg::ChNul, ctok_pkg::KindEnd, 1'b0, ctok_pkg::line_t'(2)}},
    '{8'h80, 1, '{8'h80, ctok_pkg::KindPunct, 1'b1, ctok_pkg::LineFirst}, NoTok}
  };

  function automatic bit letter_byte(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic bit digit_byte(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic bit blank_byte(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [7:0] pick_from(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic report(input string msg);
    fail_count++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic lex_clear();
    lex_mode   = ctok_pkg::ModeBetween;
    slash_pend = 1'b0;
    esc_pend   = 1'b0;
    star_pend  = 1'b0;
    cur_line   = ctok_pkg::LineFirst;
  endtask

  task automatic line_up();
    if (cur_line != ctok_pkg::LineMax) cur_line++;
  endtask

  task automatic add_token(input logic [7:0] b, input ctok_pkg::kind_e k, input logic s);
    ctok_pkg::res_t r;
    r.ch    = b;
    r.kind  = k;
    r.start = s;
    r.line  = cur_line;
    step_out.push_back(r);
  endtask

  // Handle a nonzero byte seen between tokens
  task automatic open_token(input logic [7:0] b);
    lex_mode = ctok_pkg::ModeBetween;
    if (blank_byte(b)) begin
      if (b == ctok_pkg::ChNl) line_up();
    end else if (b == ctok_pkg::ChSlash) begin
      slash_pend = 1'b1;
    end else if (letter_byte(b) || b == ctok_pkg::ChUnder) begin
      lex_mode = ctok_pkg::ModeIdent;
      add_token(b, ctok_pkg::KindIdent, 1'b1);
    end else if (digit_byte(b)) begin
      lex_mode = ctok_pkg::ModeNumber;
      add_token(b, ctok_pkg::KindNumber, 1'b1);
    end else if (b == ctok_pkg::ChDquote) begin
      lex_mode = ctok_pkg::ModeString;
      esc_pend = 1'b0;
      add_token(b, ctok_pkg::KindString, 1'b1);
    end else if (b == ctok_pkg::ChSquote) begin
      lex_mode = ctok_pkg::ModeChar;
      esc_pend = 1'b0;
      add_token(b, ctok_pkg::KindChar, 1'b1);
    end else begin
      add_token(b, ctok_pkg::KindPunct, 1'b1);
    end
  endtask

  // Advance the predicted lexer by one source byte, leaving its tokens in step_out
  task automatic lex_byte(input logic [7:0] b);
    logic [7:0]      quote;
    ctok_pkg::kind_e lit_kind;
    step_out.delete();
    if (b == ctok_pkg::ChNul) begin
      if (slash_pend) add_token(ctok_pkg::ChSlash, ctok_pkg::KindPunct, 1'b1);
      add_token(ctok_pkg::ChNul, ctok_pkg::KindEnd, 1'b0);
      lex_clear();
    end else if (slash_pend) begin
      slash_pend = 1'b0;
      if (b == ctok_pkg::ChSlash) begin
        lex_mode = ctok_pkg::ModeLineCom;
      end else if (b == ctok_pkg::ChStar) begin
        lex_mode  = ctok_pkg::ModeBlockCom;
        star_pend = 1'b0;
      end else begin
        add_token(ctok_pkg::ChSlash, ctok_pkg::KindPunct, 1'b1);
        open_token(b);
      end
    end else begin
      case (lex_mode)
        ctok_pkg::ModeIdent: begin
          if (letter_byte(b) || digit_byte(b) || b == ctok_pkg::ChUnder)
            add_token(b, ctok_pkg::KindIdent, 1'b0);
          else open_token(b);
        end
        ctok_pkg::ModeNumber: begin
          if (digit_byte(b) || b == ctok_pkg::ChDot || b == ctok_pkg::ChLowE ||
              b == ctok_pkg::ChUpE || b == ctok_pkg::ChPlus || b == ctok_pkg::ChMinus)
            add_token(b, ctok_pkg::KindNumber, 1'b0);
          else open_token(b);
        end
        ctok_pkg::ModeString, ctok_pkg::ModeChar: begin
          quote    = (lex_mode == ctok_pkg::ModeString) ? ctok_pkg::ChDquote
                                                        : ctok_pkg::ChSquote;
          lit_kind = (lex_mode == ctok_pkg::ModeString) ? ctok_pkg::KindString
                                                        : ctok_pkg::KindChar;
          if (esc_pend) esc_pend = 1'b0;
          else if (b == ctok_pkg::ChBslash) esc_pend = 1'b1;
          else if (b == quote) lex_mode = ctok_pkg::ModeBetween;
          add_token(b, lit_kind, 1'b0);
        end
        ctok_pkg::ModeLineCom: begin
          if (b == ctok_pkg::ChNl) begin
            lex_mode = ctok_pkg::ModeBetween;
            line_up();
          end
        end
        ctok_pkg::ModeBlockCom: begin
          if (star_pend && b == ctok_pkg::ChSlash) begin
            lex_mode  = ctok_pkg::ModeBetween;
            star_pend = 1'b0;
          end else begin
            star_pend = (b == ctok_pkg::ChStar);
            if (b == ctok_pkg::ChNl) line_up();
          end
        end
        default: open_token(b);
      endcase
    end
  endtask

  // Offer one byte, hold it until accepted, then predict what it causes.
  // Entered and left at a falling edge.
  task automatic push_byte(input logic [7:0] b, input bit use_model);
    int gap;
    gap = pick_gap(src_pct);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    lex_byte(b);
    if (use_model) foreach (step_out[k]) pending_tokens.push_back(step_out[k]);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Build one C-like fragment; most are well formed, a few are raw noise
  task automatic build_fragment();
    int sel;
    int n;
    frag.delete();
    sel = $urandom_range(0, 99);
    if (sel < 22) begin
      frag.push_back(pick_from("abcxyzABCXYZ_qQ"));
      n = $urandom_range(0, 7);
      repeat (n) frag.push_back(pick_from("abzAZ_09x5"));
    end else if (sel < 34) begin
      frag.push_back(pick_from("0123456789"));
      n = $urandom_range(0, 5);
      repeat (n) frag.push_back(pick_from("0179.eE+-x"));
    end else if (sel < 44 || sel < 50) begin
      frag.push_back(sel < 44 ? ctok_pkg::ChDquote : ctok_pkg::ChSquote);
      n = $urandom_range(0, 8);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: begin
            frag.push_back(ctok_pkg::ChBslash);
            frag.push_back(8'($urandom_range(1, 255)));
          end
          1: frag.push_back(8'($urandom_range(1, 255)));
          default: frag.push_back(pick_from("ab Z9\n\t/*"));
        endcase
      end
      if ($urandom_range(0, 9) != 0)
        frag.push_back(sel < 44 ? ctok_pkg::ChDquote : ctok_pkg::ChSquote);
    end else if (sel < 56) begin
      frag.push_back(ctok_pkg::ChSlash);
      frag.push_back(ctok_pkg::ChSlash);
      n = $urandom_range(0, 10);
      repeat (n) frag.push_back(pick_from("ab */\t\"'x"));
      frag.push_back(ctok_pkg::ChNl);
    end else if (sel < 62) begin
      frag.push_back(ctok_pkg::ChSlash);
      frag.push_back(ctok_pkg::ChStar);
      n = $urandom_range(0, 10);
      repeat (n) frag.push_back(pick_from("ab **/\n\"x"));
      frag.push_back(ctok_pkg::ChStar);
      frag.push_back(ctok_pkg::ChSlash);
    end else if (sel < 78) begin
      frag.push_back(pick_from("+-*%=<>!&|^~?:;,.()[]{}#//"));
    end else if (sel < 92) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) frag.push_back(8'($urandom_range(9, 13)));
        else frag.push_back(pick_from(" \t\n"));
      end
    end else if (sel < 98) begin
      frag.push_back(8'($urandom_range(1, 255)));
    end else begin
      frag.push_back(ctok_pkg::ChNul);
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle budget and input backpressure count
  always @(posedge clk_i) begin
    cycle_count++;
    if (in_valid_i && in_stall_o) in_held_cycles++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin : sink
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        n = HoldOffCycles;
      end else begin
        n = pick_gap(dst_pct);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each output transaction with the oldest owed token
  always @(posedge clk_i) begin : check_tokens
    ctok_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tokens.size() == 0) begin
        report($sformatf("token %02h kind %0d with none owed", out_char_o, token_kind_o));
      end else begin
        want = pending_tokens.pop_front();
        tokens_checked++;
        if (want.kind == ctok_pkg::KindEnd) ends_seen++;
        if (out_char_o !== want.ch)
          report($sformatf("out_char %02h, want %02h", out_char_o, want.ch));
        if (token_kind_o !== want.kind)
          report($sformatf("token_kind %0d, want %0d (char %02h)", token_kind_o, want.kind,
                           want.ch));
        if (token_start_o !== want.start)
          report($sformatf("token_start %0b, want %0b (char %02h)", token_start_o, want.start,
                           want.ch));
        if (line_number_o !== want.line)
          report($sformatf("line_number %0d, want %0d (char %02h)", line_number_o, want.line,
                           want.ch));
      end
    end
  end

  // Stimulus
  initial begin : source
    int sent;
    int next_phase;
    int levels[3];
    bit hold_done;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_code_i = 8'h00;
    hold_req    = 1'b0;
    src_pct     = 30;
    dst_pct     = 30;
    levels      = '{0, 15, 50};
    hold_done   = 1'b0;
    lex_clear();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed source
    foreach (script[i]) begin
      push_byte(script[i].ch, script[i].n_typed == 0);
      if (script[i].n_typed > 0) pending_tokens.push_back(script[i].t0);
      if (script[i].n_typed > 1) pending_tokens.push_back(script[i].t1);
    end

    // Random source in phases of differing idle pressure
    sent       = 0;
    next_phase = 0;
    while (sent < RandomBytes) begin
      if (sent >= next_phase) begin
        src_pct     = levels[$urandom_range(0, 2)];
        dst_pct     = levels[$urandom_range(0, 2)];
        next_phase += PhaseBytes;
      end
      // Hold off the output while bytes keep coming, to fill the block
      if (!hold_done && sent >= 400) begin
        hold_done = 1'b1;
        src_pct   = 0;
        hold_req  = 1'b1;
      end
      build_fragment();
      foreach (frag[j]) push_byte(frag[j], 1'b1);
      sent += frag.size();
    end

    // Count a few lines, flush a held slash at the end, then restart at line one
    src_pct = 0;
    dst_pct = 0;
    push_byte(ctok_pkg::ChNul, 1'b1);
    repeat (3) push_byte(ctok_pkg::ChNl, 1'b1);
    push_byte(8'h6B, 1'b1);
    push_byte(ctok_pkg::ChSlash, 1'b1);
    push_byte(ctok_pkg::ChNul, 1'b1);
    push_byte(8'h71, 1'b1);
    in_valid_i <= 1'b0;

    // Drain the owed tokens, then watch a little longer for strays
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d source bytes (directed, random C fragments, line restart).",
             bytes_sent);
    $display("Checked %0d tokens, %0d end items; input held off for %0d cycles.",
             tokens_checked, ends_seen, in_held_cycles);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
